// File: hw/rtl/mfpf_pkg.sv
// Shared constants and types for the monochrome page frame store.
package mfpf_pkg;

  localparam int unsigned ScreenWidthDefault  = 128;
  localparam int unsigned ScreenHeightDefault = 32;

  typedef enum logic [1:0] {
    OpDraw  = 2'd0,
    OpClear = 2'd1,
    OpFlush = 2'd2
  } op_e;

  localparam logic KindCmd  = 1'b0;
  localparam logic KindData = 1'b1;

  localparam logic [7:0] CmdPageBase = 8'hB0;
  localparam logic [7:0] CmdColLow   = 8'h00;
  localparam logic [7:0] CmdColHigh  = 8'h10;

endpackage

// File: hw/rtl/mfpf_ram.sv
// Generic single-port RAM with registered read data.
module mfpf_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/mono_framebuffer_page_flush.sv
// Top level: page-organized monochrome frame store with draw, clear and page flush.
//
//   channel | direction | fields
//   in      | sink      | operation_i, x_coord_i, y_coord_i, pixel_on_i, page_index_i
//   out     | source    | item_kind_o, payload_o, last_of_run_o
//
// Store: one RAM word of eight column bytes, PageCount * WordsPerPage words.
// Draw reads the addressed word, then writes it back with the one pixel bit changed;
// an off-screen draw is dropped. Clear writes zero to every RAM word in turn.
// Flush emits a page command item, then for each word of the page one RAM read followed
// by one output-register load; a flush of a page index out of range is dropped.
// After reset a clearing pass over every RAM word runs before the first transfer.
// out stall holds the output register; the next input is taken once the last result is loaded.
module mono_framebuffer_page_flush
  import mfpf_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = ScreenWidthDefault,
  parameter int unsigned SCREEN_HEIGHT = ScreenHeightDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  x_coord_i,
  input  logic [7:0]  y_coord_i,
  input  logic        pixel_on_i,
  input  logic [2:0]  page_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [63:0] payload_o,
  output logic        last_of_run_o
);

  localparam int unsigned PageCount    = (SCREEN_HEIGHT + 7) / 8;
  localparam int unsigned WordsPerPage = (SCREEN_WIDTH + 7) / 8;
  localparam int unsigned Depth        = PageCount * WordsPerPage;
  localparam int unsigned AddrW        = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned WcW          = (WordsPerPage > 1) ? $clog2(WordsPerPage) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [WcW-1:0]   LastWord = WcW'(WordsPerPage - 1);
  localparam logic [8:0]       WidthLim  = 9'(SCREEN_WIDTH);
  localparam logic [8:0]       HeightLim = 9'(SCREEN_HEIGHT);
  localparam logic [3:0]       PageLim   = 4'(PageCount);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StClear  = 6'b000010,
    StDrawWr = 6'b000100,
    StFlCmd  = 6'b001000,
    StFlRd   = 6'b010000,
    StFlOut  = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [WcW-1:0]   word_q, word_d;
  logic [5:0]       bit_sel_q, bit_sel_d;
  logic             on_q, on_d;
  logic [2:0]       page_q, page_d;

  logic        out_valid_q, out_valid_d;
  logic        kind_q, kind_d;
  logic [63:0] payload_q, payload_d;
  logic        last_q, last_d;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_addr;
  logic [63:0]      ram_wdata, ram_rdata;

  logic             out_free;
  logic             in_xfer;
  logic             on_screen;
  logic             page_ok;
  logic [AddrW-1:0] draw_addr;
  logic [AddrW-1:0] flush_base;

  mfpf_ram #(
    .Width(64),
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign on_screen  = ({1'b0, x_coord_i} < WidthLim) && ({1'b0, y_coord_i} < HeightLim);
  assign page_ok    = ({1'b0, page_index_i} < PageLim);
  assign draw_addr  = AddrW'(int'(y_coord_i[7:3]) * WordsPerPage + int'(x_coord_i[7:3]));
  assign flush_base = AddrW'(int'(page_index_i) * WordsPerPage);

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    word_d      = word_q;
    bit_sel_d   = bit_sel_q;
    on_d        = on_q;
    page_d      = page_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    payload_d   = payload_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = addr_q;
    ram_wdata   = ram_rdata;

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          case (op_e'(operation_i))
            OpDraw: begin
              if (on_screen) begin
                ram_re    = 1'b1;
                ram_addr  = draw_addr;
                addr_d    = draw_addr;
                bit_sel_d = {x_coord_i[2:0], y_coord_i[2:0]};
                on_d      = pixel_on_i;
                state_d   = StDrawWr;
              end
            end
            OpClear: begin
              addr_d  = '0;
              state_d = StClear;
            end
            OpFlush: begin
              if (page_ok) begin
                page_d  = page_index_i;
                addr_d  = flush_base;
                word_d  = '0;
                state_d = StFlCmd;
              end
            end
            default: ;
          endcase
        end
      end
      StClear: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (addr_q == LastAddr) begin
          state_d = StIdle;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      StDrawWr: begin
        ram_we               = 1'b1;
        ram_wdata[bit_sel_q] = on_q;
        state_d              = StIdle;
      end
      StFlCmd: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = KindCmd;
          payload_d   = {40'd0, CmdColHigh, CmdColLow, CmdPageBase + {5'd0, page_q}};
          last_d      = 1'b0;
          state_d     = StFlRd;
        end
      end
      StFlRd: begin
        ram_re  = 1'b1;
        state_d = StFlOut;
      end
      StFlOut: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = KindData;
          payload_d   = ram_rdata;
          last_d      = (word_q == LastWord);
          if (word_q == LastWord) begin
            state_d = StIdle;
          end else begin
            addr_d  = addr_q + 1'b1;
            word_d  = word_q + 1'b1;
            state_d = StFlRd;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      addr_q      <= '0;
      word_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      word_q      <= word_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_sel_q <= bit_sel_d;
    on_q      <= on_d;
    page_q    <= page_d;
    kind_q    <= kind_d;
    payload_q <= payload_d;
    last_q    <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign item_kind_o   = kind_q;
  assign payload_o     = payload_q;
  assign last_of_run_o = last_q;

endmodule
